// File: rtl/core/vpa_pkg.sv
// ----------------------------------------------------------------------------
// vpa_pkg
// Shared types and constants of the variable partition allocator.
// ----------------------------------------------------------------------------
package vpa_pkg;

  localparam int unsigned MemBytesDefault  = 1048576;
  localparam int unsigned MaxBlocksDefault = 64;

  localparam int unsigned CmdW    = 1;
  localparam int unsigned OwnerW  = 8;
  localparam int unsigned ReqW    = 21;
  localparam int unsigned AddrW   = 20;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PolicyW = 2;

  localparam logic [CmdW-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CmdW-1:0] CMD_FREE  = 1'b1;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_NOFIT = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
  localparam logic [StatusW-1:0] ST_ZERO  = 2'd3;

  localparam logic [PolicyW-1:0] POL_FIRST = 2'd0;
  localparam logic [PolicyW-1:0] POL_BEST  = 2'd1;
  localparam logic [PolicyW-1:0] POL_WORST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SPLIT,
    S_TAKE,
    S_MERGE,
    S_FLUSH,
    S_DONE
  } vpa_state_t;

  // one entry of the block table
  typedef struct packed {
    logic [AddrW-1:0]  start;
    logic [ReqW-1:0]   size;
    logic              free;
    logic [OwnerW-1:0] owner;
  } vpa_entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request
    logic scan_step;   // read and examine entries
    logic decide;      // latch full flag, prepare split shift
    logic shift_step;  // move entries up by one
    logic split_write; // write the free remainder
    logic take;        // write the taken entry
    logic merge_step;  // release and compact entries
    logic merge_flush; // write last entry, commit count
    logic set_result;
  } vpa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free_cmd;
    logic zero_size;
    logic scan_done;
    logic found;
    logic need_split;
    logic table_full;
    logic shift_done;
    logic merge_done;
  } vpa_stat_t;

endpackage

// File: rtl/core/vpa_if.sv
// ----------------------------------------------------------------------------
// vpa_req_if / vpa_rsp_if
// Valid/ready channels carrying request and result beats.
// ----------------------------------------------------------------------------
interface vpa_req_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [7:0]  owner_id;
  logic [20:0] request_size;
  modport source (output valid, command, owner_id, request_size, input ready);
  modport sink (input valid, command, owner_id, request_size, output ready);
endinterface

interface vpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [19:0] start_address;
  modport source (output valid, status, start_address, input ready);
  modport sink (input valid, status, start_address, output ready);
endinterface

// File: rtl/core/vpa_ctrl.sv
// ----------------------------------------------------------------------------
// vpa_ctrl
// Sequencer: scan, split shift, combined owner release and merge pass.
// ----------------------------------------------------------------------------
module vpa_ctrl import vpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  vpa_stat_t stat,
  output vpa_cmd_t  cmd
);

  vpa_state_t state, state_next;
  logic       pend, pend_next;

  // state register and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  assign out_valid = pend;
  assign in_ready  = (state == S_IDLE) && !pend;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid && in_ready) state_next = S_SCAN;
      S_SCAN: begin
        if (stat.is_free_cmd) state_next = S_MERGE;
        else if (stat.zero_size) state_next = S_DONE;
        else if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.found && stat.need_split && !stat.table_full) state_next = S_SHIFT;
        else if (stat.found && !stat.need_split) state_next = S_TAKE;
        else state_next = S_DONE;
      end
      S_SHIFT:  if (stat.shift_done) state_next = S_SPLIT;
      S_SPLIT:  state_next = S_TAKE;
      S_TAKE:   state_next = S_DONE;
      S_MERGE:  if (stat.merge_done) state_next = S_FLUSH;
      S_FLUSH:  state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    pend_next = pend && !out_ready;
    unique case (state)
      S_IDLE:   cmd.load = in_valid && in_ready;
      S_SCAN:   cmd.scan_step = !stat.is_free_cmd && !stat.zero_size && !stat.scan_done;
      S_DECIDE: cmd.decide = 1'b1;
      S_SHIFT:  cmd.shift_step = !stat.shift_done;
      S_SPLIT:  cmd.split_write = 1'b1;
      S_TAKE:   cmd.take = 1'b1;
      S_MERGE:  cmd.merge_step = !stat.merge_done;
      S_FLUSH:  cmd.merge_flush = 1'b1;
      S_DONE: begin
        cmd.set_result = 1'b1;
        pend_next      = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/vpa_dp.sv
// ----------------------------------------------------------------------------
// vpa_dp
// Block table in a memory with registered reads, one entry read per cycle.
// Entry zero is written with the whole memory while reset is held.
// ----------------------------------------------------------------------------
module vpa_dp import vpa_pkg::*; #(
  parameter int unsigned MEM_BYTES  = MemBytesDefault,
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [PolicyW-1:0] fit_policy,
  input  logic               command,
  input  logic [OwnerW-1:0]  owner_id,
  input  logic [ReqW-1:0]    request_size,
  input  vpa_cmd_t           cmd,
  output vpa_stat_t          stat,
  output logic [StatusW-1:0] status,
  output logic [AddrW-1:0]   start_address
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);

  vpa_entry_t        blk_mem [MAX_BLOCKS];
  vpa_entry_t        rdata;
  vpa_entry_t        wdata;
  vpa_entry_t        acc;   // merged entry waiting to be written
  logic              re;
  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [CntW-1:0]   count;
  logic [CntW-1:0]   raddr; // read pointer
  logic [CntW-1:0]   wcnt;  // entries kept by the merge pass
  logic              rd_ok;
  logic [IdxW-1:0]   rd_idx;

  logic              r_cmd;
  logic [OwnerW-1:0] r_owner;
  logic [ReqW-1:0]   r_size;
  logic              found;
  logic              blocked;
  logic [IdxW-1:0]   chosen;
  logic [ReqW-1:0]   csize;
  logic [AddrW-1:0]  cstart;

  logic first_fit, fits, better, rel_free, joins, merge_wr;

  assign first_fit = (fit_policy != POL_BEST) && (fit_policy != POL_WORST);
  assign fits      = rdata.free && (rdata.size >= r_size);
  always_comb begin
    priority if (!found) better = 1'b1;
    else if (fit_policy == POL_BEST) better = rdata.size < csize;
    else if (fit_policy == POL_WORST) better = rdata.size > csize;
    else better = 1'b0;
  end

  // owner release folded into the compaction pass
  assign rel_free = rdata.free || (rdata.owner == r_owner);
  assign joins    = (wcnt != '0) && acc.free && rel_free;
  assign merge_wr = cmd.merge_step && rd_ok && !joins && (wcnt != '0);

  // read issue: scan and merge walk up, shift walks down
  assign re = (cmd.scan_step && (raddr < count) && !(found && first_fit)) ||
              (cmd.shift_step && (raddr > CntW'(chosen))) ||
              (cmd.merge_step && (raddr < count));

  // status towards the controller
  always_comb begin
    stat             = '0;
    stat.is_free_cmd = (r_cmd == CMD_FREE);
    stat.zero_size   = (r_size == '0);
    stat.scan_done   = (found && first_fit) || ((raddr >= count) && !rd_ok);
    stat.found       = found;
    stat.need_split  = csize > r_size;
    stat.table_full  = count >= CntW'(MAX_BLOCKS);
    stat.shift_done  = (raddr <= CntW'(chosen)) && !rd_ok;
    stat.merge_done  = (raddr >= count) && !rd_ok;
  end

  // write port select
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    priority if (rst) begin
      we         = 1'b1;
      wdata.size = ReqW'(MEM_BYTES);
      wdata.free = 1'b1;
    end else if (cmd.shift_step && rd_ok) begin
      we    = 1'b1;
      waddr = rd_idx + IdxW'(1);
      wdata = rdata;
    end else if (cmd.split_write) begin
      we          = 1'b1;
      waddr       = chosen + IdxW'(1);
      wdata.start = cstart + AddrW'(r_size);
      wdata.size  = csize - r_size;
      wdata.free  = 1'b1;
    end else if (cmd.take) begin
      we          = 1'b1;
      waddr       = chosen;
      wdata.start = cstart;
      wdata.size  = r_size;
      wdata.owner = r_owner;
    end else if (merge_wr || cmd.merge_flush) begin
      we    = 1'b1;
      waddr = IdxW'(wcnt - CntW'(1));
      wdata = acc;
    end else begin
      we = 1'b0;
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) blk_mem[waddr] <= wdata;
    if (re) rdata <= blk_mem[raddr[IdxW-1:0]];
  end

  // request, pointer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= CntW'(1);
      raddr         <= '0;
      wcnt          <= '0;
      rd_ok         <= 1'b0;
      found         <= 1'b0;
      blocked       <= 1'b0;
      status        <= ST_OK;
      start_address <= '0;
    end else begin
      rd_ok <= re;
      if (re) rd_idx <= raddr[IdxW-1:0];
      if (cmd.load) begin
        r_cmd   <= command;
        r_owner <= owner_id;
        r_size  <= request_size;
        found   <= 1'b0;
        blocked <= 1'b0;
        wcnt    <= '0;
      end
      // read pointer
      priority if (cmd.load) raddr <= '0;
      else if (cmd.decide) raddr <= count - CntW'(1);
      else if (re && cmd.shift_step) raddr <= raddr - CntW'(1);
      else if (re) raddr <= raddr + CntW'(1);
      else raddr <= raddr;
      // candidate tracking during the scan
      if (cmd.scan_step && rd_ok && fits && better) begin
        found  <= 1'b1;
        chosen <= rd_idx;
        csize  <= rdata.size;
        cstart <= rdata.start;
      end
      if (cmd.decide) blocked <= stat.table_full;
      // release and compaction
      if (cmd.merge_step && rd_ok) begin
        if (joins) begin
          acc.size <= acc.size + rdata.size;
        end else begin
          acc.start <= rdata.start;
          acc.size  <= rdata.size;
          acc.free  <= rel_free;
          acc.owner <= rdata.owner;
          wcnt      <= wcnt + CntW'(1);
        end
      end
      if (cmd.split_write) count <= count + CntW'(1);
      else if (cmd.merge_flush) count <= wcnt;
      if (cmd.set_result) begin
        priority if (r_cmd == CMD_FREE) begin
          status <= ST_OK;
          start_address <= '0;
        end else if (r_size == '0) begin
          status <= ST_ZERO;
          start_address <= '0;
        end else if (!found) begin
          status <= ST_NOFIT;
          start_address <= '0;
        end else if (csize > r_size && blocked) begin
          status <= ST_FULL;
          start_address <= '0;
        end else begin
          status <= ST_OK;
          start_address <= cstart;
        end
      end
    end
  end

endmodule

// File: rtl/core/variable_partition_allocator_top.sv
// ----------------------------------------------------------------------------
// variable_partition_allocator_top
// First, best and worst fit allocator over an ordered block table.
// ----------------------------------------------------------------------------
// One request is taken at a time; the table sits in a memory read one entry
// per cycle. An allocate scans the table (first fit stops at the first
// fitting entry) and decides; for a split it moves the entries above the
// chosen entry k up by one, then writes the free remainder and the taken
// entry. An exact fit writes only the taken entry; no fit, a zero size and
// a split with a full table write nothing. A free releases and merges in
// one pass. A result beat waits in an output register; the next request is
// taken the cycle after it is accepted.
module variable_partition_allocator_top import vpa_pkg::*; #(
  parameter int unsigned MEM_BYTES  = MemBytesDefault,
  parameter int unsigned MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [PolicyW-1:0] cfg_wdata,
  vpa_req_if.sink            req,
  vpa_rsp_if.source          rsp
);

  logic [PolicyW-1:0] fit_policy;
  vpa_cmd_t           cmd;
  vpa_stat_t          stat;

  // policy register
  always_ff @(posedge clk) begin
    if (rst) fit_policy <= POL_FIRST;
    else if (cfg_we) fit_policy <= cfg_wdata;
  end

  vpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  vpa_dp #(.MEM_BYTES(MEM_BYTES), .MAX_BLOCKS(MAX_BLOCKS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .fit_policy    (fit_policy),
    .command       (req.command),
    .owner_id      (req.owner_id),
    .request_size  (req.request_size),
    .cmd           (cmd),
    .stat          (stat),
    .status        (rsp.status),
    .start_address (rsp.start_address)
  );

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the variable partition allocator. Allocate and
// free requests are sent over the request channel. A predictor keeps its own
// block table and works out the status and start address of every beat. The
// predictor result is checked against each response beat. Runs go through all
// fit policies, with random idling on both sides and a long receiver stall.
// ----------------------------------------------------------------------------
module tb;
  import vpa_pkg::*;

  localparam int unsigned MemBytes  = MemBytesDefault;
  localparam int unsigned MaxBlocks = MaxBlocksDefault;
  localparam int          CycleLimit = 1500000;

  typedef struct {
    logic              cmd;
    logic [OwnerW-1:0] owner;
    logic [ReqW-1:0]   size;
  } alloc_req_t;

  typedef struct {
    logic [StatusW-1:0] status;
    logic [AddrW-1:0]   addr;
  } alloc_rsp_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [PolicyW-1:0] cfg_wdata;

  vpa_req_if req_ch ();
  vpa_rsp_if rsp_ch ();

  variable_partition_allocator_top #(
    .MEM_BYTES  (MemBytes),
    .MAX_BLOCKS (MaxBlocks)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // predictor copy of the block table
  int                 tbl_start [MaxBlocks];
  int                 tbl_size  [MaxBlocks];
  bit                 tbl_free  [MaxBlocks];
  logic [OwnerW-1:0]  tbl_owner [MaxBlocks];
  int                 tbl_count;
  logic [PolicyW-1:0] fit_sel;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  alloc_req_t cur_req;
  bit         beat_taken;
  int         n_pushed;
  int         n_accepted;
  int         n_errors;
  int         cycles;
  int         send_idle;
  int         recv_idle;
  int         stall_reqs;
  int         stall_seen;
  int         stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d expected %0d (beat %0d)", what, got, want,
             n_accepted);
    n_errors++;
  endtask

  // index of the free block chosen by the policy, or -1
  function automatic int choose_block(int size);
    int pick;
    pick = -1;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_size[i] >= size) begin
        if (pick < 0) begin
          pick = i;
          if (fit_sel != POL_BEST && fit_sel != POL_WORST) return pick;
        end else if (fit_sel == POL_BEST && tbl_size[i] < tbl_size[pick]) begin
          pick = i;
        end else if (fit_sel == POL_WORST && tbl_size[i] > tbl_size[pick]) begin
          pick = i;
        end
      end
    end
    return pick;
  endfunction

  // apply one request to the table and return the expected beat
  function automatic alloc_rsp_t allocate_or_release(alloc_req_t r);
    alloc_rsp_t res;
    int         k;
    int         w;
    int         sz;
    res.status = ST_OK;
    res.addr   = '0;
    sz         = int'(r.size);
    if (r.cmd == CMD_FREE) begin
      for (int i = 0; i < tbl_count; i++)
        if (!tbl_free[i] && tbl_owner[i] == r.owner) tbl_free[i] = 1'b1;
      // coalesce neighbouring free blocks
      w = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (w > 0 && tbl_free[w-1] && tbl_free[i]) begin
          tbl_size[w-1] += tbl_size[i];
        end else begin
          tbl_start[w] = tbl_start[i];
          tbl_size[w]  = tbl_size[i];
          tbl_free[w]  = tbl_free[i];
          tbl_owner[w] = tbl_owner[i];
          w++;
        end
      end
      tbl_count = w;
    end else if (sz == 0) begin
      res.status = ST_ZERO;
    end else begin
      k = choose_block(sz);
      if (k < 0) begin
        res.status = ST_NOFIT;
      end else begin
        if (tbl_size[k] > sz) begin
          if (tbl_count >= MaxBlocks) begin
            res.status = ST_FULL;
          end else begin
            for (int j = tbl_count; j > k + 1; j--) begin
              tbl_start[j] = tbl_start[j-1];
              tbl_size[j]  = tbl_size[j-1];
              tbl_free[j]  = tbl_free[j-1];
              tbl_owner[j] = tbl_owner[j-1];
            end
            tbl_start[k+1] = tbl_start[k] + sz;
            tbl_size[k+1]  = tbl_size[k] - sz;
            tbl_free[k+1]  = 1'b1;
            tbl_owner[k+1] = '0;
            tbl_count++;
          end
        end
        if (res.status == ST_OK) begin
          tbl_free[k]  = 1'b0;
          tbl_size[k]  = sz;
          tbl_owner[k] = r.owner;
          res.addr     = tbl_start[k][AddrW-1:0];
        end
      end
    end
    return res;
  endfunction

  // accepted request beat: predict its result
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      expected_rsps = {expected_rsps, allocate_or_release(cur_req)};
      n_accepted++;
      beat_taken = 1'b1;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (!rst && (!req_ch.valid || beat_taken)) begin
      beat_taken = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur_req             = pending_reqs.pop_front();
        req_ch.command      = cur_req.cmd;
        req_ch.owner_id     = cur_req.owner;
        req_ch.request_size = cur_req.size;
        req_ch.valid        = 1'b1;
      end else begin
        req_ch.valid = 1'b0;
      end
    end
  end

  // response ready, with an occasional long hold-off
  always @(negedge clk) begin
    if (stall_reqs != stall_seen) begin
      stall_seen = stall_reqs;
      stall_left = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready = 1'b0;
    end else begin
      rsp_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  // response monitor
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("response beat with nothing expected");
        n_errors++;
      end else begin
        want = expected_rsps.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.start_address !== want.addr)
          report_mismatch("start_address", rsp_ch.start_address, want.addr);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_req(logic cmd, logic [OwnerW-1:0] owner, logic [ReqW-1:0] size);
    alloc_req_t r;
    r.cmd   = cmd;
    r.owner = owner;
    r.size  = size;
    pending_reqs = {pending_reqs, r};
    n_pushed++;
  endtask

  // wait until every beat is sent and answered
  task automatic drain();
    while (n_accepted != n_pushed || expected_rsps.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_policy(logic [PolicyW-1:0] pol);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = pol;
    @(negedge clk);
    cfg_we  = 1'b0;
    fit_sel = pol;
  endtask

  // random requests, mostly small allocations and frees over a few owners
  task automatic random_burst(int n, bit with_stall);
    int                k;
    int                sel;
    logic [OwnerW-1:0] own;
    logic [ReqW-1:0]   sz;
    for (int i = 0; i < n; i++) begin
      while (pending_reqs.size() != 0) @(negedge clk);
      if (with_stall && i == n / 2) stall_reqs++;
      own = ($urandom_range(9) == 0) ? OwnerW'($urandom) : OwnerW'($urandom_range(15));
      sel = $urandom_range(99);
      if (sel < 22) begin
        push_req(CMD_FREE, own, ReqW'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (sel < 55) sz = ReqW'($urandom_range(4096, 1));
        else if (sel < 72) sz = ReqW'($urandom_range(65536, 1));
        else if (sel < 80) sz = ReqW'($urandom_range(MemBytes, 1));
        else if (sel < 84) sz = '0;
        else if (sel < 88) sz = ReqW'($urandom);
        else begin
          // exact fit on a free block of the table
          sz = ReqW'($urandom_range(2048, 1));
          k  = $urandom_range(tbl_count - 1);
          for (int j = 0; j < tbl_count; j++)
            if (tbl_free[(k + j) % tbl_count]) begin
              sz = ReqW'(tbl_size[(k + j) % tbl_count]);
              break;
            end
        end
        push_req(CMD_ALLOC, own, sz);
      end
    end
  endtask

  // stimulus
  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    req_ch.valid        = 1'b0;
    req_ch.command      = CMD_ALLOC;
    req_ch.owner_id     = '0;
    req_ch.request_size = '0;
    rsp_ch.ready        = 1'b0;
    beat_taken          = 1'b0;
    n_pushed            = 0;
    n_accepted          = 0;
    n_errors            = 0;
    cycles              = 0;
    send_idle           = 28;
    recv_idle           = 70;
    stall_reqs          = 0;
    stall_seen          = 0;
    stall_left          = 0;
    for (int i = 0; i < MaxBlocks; i++) begin
      tbl_start[i] = 0;
      tbl_size[i]  = 0;
      tbl_free[i]  = 1'b0;
      tbl_owner[i] = '0;
    end
    tbl_size[0] = MemBytes;
    tbl_free[0] = 1'b1;
    tbl_count   = 1;
    fit_sel     = POL_FIRST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: zero size, oversize, whole memory, frees, field extremes
    push_req(CMD_ALLOC, 8'd3, '0);
    push_req(CMD_ALLOC, 8'd3, {ReqW{1'b1}});
    push_req(CMD_ALLOC, 8'd0, ReqW'(MemBytes));
    push_req(CMD_ALLOC, 8'd255, ReqW'(1));
    push_req(CMD_FREE, 8'd77, '0);
    push_req(CMD_FREE, 8'd0, {ReqW{1'b1}});
    push_req(CMD_ALLOC, 8'd255, ReqW'(1));
    push_req(CMD_ALLOC, 8'd1, ReqW'(MemBytes / 2));
    push_req(CMD_ALLOC, 8'd2, ReqW'(100));
    push_req(CMD_ALLOC, 8'd1, ReqW'(MemBytes));
    push_req(CMD_FREE, 8'd255, '0);
    push_req(CMD_ALLOC, 8'd170, ReqW'(1));
    push_req(CMD_FREE, 8'd1, '0);
    push_req(CMD_FREE, 8'd2, '0);
    push_req(CMD_FREE, 8'd170, '0);
    push_req(CMD_ALLOC, 8'd85, ReqW'(MemBytes - 1));
    push_req(CMD_FREE, 8'd85, '0);
    drain();

    // phase one: best fit, receiver mostly stalled, with a long hold-off
    write_policy(POL_BEST);
    random_burst(400, 1'b1);
    drain();

    // phase two: worst fit, sender mostly idle
    send_idle = 70;
    recv_idle = 28;
    write_policy(POL_WORST);
    random_burst(400, 1'b0);
    drain();

    // phase three: unused policy then first fit with a long hold-off, no idling
    send_idle = 0;
    recv_idle = 0;
    write_policy(2'd3);
    random_burst(200, 1'b0);
    drain();
    write_policy(POL_FIRST);
    random_burst(200, 1'b1);
    drain();

    repeat (300) @(negedge clk);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
